// File: hdl/assert_macros.svh
// Assertion macros shared by the line-of-walk checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked implication check, disabled while reset is asserted.
`define GLW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("glw assertion failed");

// Condition that must never be true on a clock edge out of reset.
`define GLW_NEVER(label, clk, rst_n, cond) \
    `GLW_ASSERT(label, clk, rst_n, !(cond))

`else

`define GLW_ASSERT(label, clk, rst_n, prop)
`define GLW_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hdl/glw_pkg.sv
// Shared constants and types of the grid line-of-walk checker.
package glw_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_HEIGHT_BITS = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    // Port widths fixed by the interface
    localparam int COORD_W   = 6;
    localparam int DIM_REG_W = 7;
    localparam int STEP_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT_STEP = 2'd2;

    // Register reset values
    localparam logic [DIM_REG_W-1:0] RST_GRID_COLS       = 7'd64;
    localparam logic [DIM_REG_W-1:0] RST_GRID_ROWS       = 7'd64;
    localparam logic [STEP_W-1:0]    RST_MAX_HEIGHT_STEP = 16'd77;  // 0.3 in 8.8

    // Transaction kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Tag that travels with each cell read of a walk
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } rd_tag_t;

endpackage

// File: hdl/glw_cell_mem.sv
// Cell store: simple dual-port synchronous RAM with a registered read port.
module glw_cell_mem
    import glw_pkg::*;
#(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 33
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/glw_line_gen.sv
// Bresenham stepper: issues one cell address per cycle from start to end.
module glw_line_gen
    import glw_pkg::*;
#(
    parameter int COL_BITS = 6,
    parameter int ROW_BITS = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [COL_BITS-1:0] x0,
    input  logic [ROW_BITS-1:0] y0,
    input  logic [COL_BITS-1:0] x1,
    input  logic [ROW_BITS-1:0] y1,
    output logic                busy,
    output logic [COL_BITS-1:0] rd_col,
    output logic [ROW_BITS-1:0] rd_row,
    output rd_tag_t             rd_tag
);

    localparam int MB = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
    localparam int EW = MB + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } state_t;

    state_t                state_reg, state_next;
    logic [COL_BITS-1:0]   x_reg, x_next, xe_reg, xe_next, dx_reg, dx_next;
    logic [ROW_BITS-1:0]   y_reg, y_next, ye_reg, ye_next, dy_reg, dy_next;
    logic                  sx_reg, sx_next, sy_reg, sy_next;
    logic                  first_reg, first_next;
    logic signed [EW-1:0]  err_reg, err_next;
    logic signed [EW-1:0]  dx_s, dy_s, e2;
    logic                  at_end, step_x, step_y;

    assign dx_s   = signed'(EW'(dx_reg));
    assign dy_s   = signed'(EW'(dy_reg));
    assign e2     = err_reg <<< 1;
    assign step_x = e2 > -dy_s;
    assign step_y = e2 < dx_s;
    assign at_end = (x_reg == xe_reg) && (y_reg == ye_reg);

    // Next-state and datapath
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        xe_next    = xe_reg;
        ye_next    = ye_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        first_next = first_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    x_next     = x0;
                    y_next     = y0;
                    xe_next    = x1;
                    ye_next    = y1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                sx_next    = x_reg < xe_reg;
                sy_next    = y_reg < ye_reg;
                dx_next    = (x_reg < xe_reg) ? (xe_reg - x_reg) : (x_reg - xe_reg);
                dy_next    = (y_reg < ye_reg) ? (ye_reg - y_reg) : (y_reg - ye_reg);
                err_next   = signed'(EW'(dx_next)) - signed'(EW'(dy_next));
                first_next = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                first_next = 1'b0;
                if (at_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    err_next = err_reg - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
                    if (step_x)
                    begin
                        x_next = sx_reg ? (x_reg + 1'b1) : (x_reg - 1'b1);
                    end
                    if (step_y)
                    begin
                        y_next = sy_reg ? (y_reg + 1'b1) : (y_reg - 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            xe_reg    <= '0;
            ye_reg    <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            sx_reg    <= 1'b0;
            sy_reg    <= 1'b0;
            err_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            xe_reg    <= xe_next;
            ye_reg    <= ye_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            err_reg   <= err_next;
        end
    end

    assign busy         = state_reg != ST_IDLE;
    assign rd_col       = x_reg;
    assign rd_row       = y_reg;
    assign rd_tag.valid = state_reg == ST_WALK;
    assign rd_tag.first = first_reg;
    assign rd_tag.last  = at_end;

endmodule

// File: hdl/glw_check.sv
// Per-cell checker: tests walkability, height step and weight change.
module glw_check
    import glw_pkg::*;
#(
    parameter int HEIGHT_BITS = 16,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rd_tag_t                             tag,
    input  logic [HEIGHT_BITS+WEIGHT_BITS:0]    cell_word,
    input  logic [STEP_W-1:0]                   max_step,
    output logic                                busy,
    output logic                                done,
    output logic                                line_clear
);

    localparam int HW = HEIGHT_BITS + 1;
    localparam int CW = (HW > STEP_W) ? HW : STEP_W;

    rd_tag_t                 tag_reg;
    logic [HEIGHT_BITS-1:0]  ph_reg;
    logic [WEIGHT_BITS-1:0]  pw_reg;
    logic                    ok_reg, ok_next;
    logic                    done_reg, clear_reg;
    logic [HEIGHT_BITS-1:0]  c_height;
    logic [WEIGHT_BITS-1:0]  c_weight;
    logic                    c_walk;
    logic signed [HW-1:0]    hdiff;
    logic [HW-1:0]           habs;
    logic                    step_ok;

    // Unpack the stored word
    assign c_height = cell_word[HEIGHT_BITS-1:0];
    assign c_weight = cell_word[HEIGHT_BITS+WEIGHT_BITS-1:HEIGHT_BITS];
    assign c_walk   = cell_word[HEIGHT_BITS+WEIGHT_BITS];

    // Full-precision height difference against the previous cell
    assign hdiff   = signed'({c_height[HEIGHT_BITS-1], c_height})
                   - signed'({ph_reg[HEIGHT_BITS-1], ph_reg});
    assign habs    = hdiff[HW-1] ? HW'(-hdiff) : HW'(hdiff);
    assign step_ok = (CW'(habs) <= CW'(max_step)) && (c_weight == pw_reg);

    always_comb
    begin
        ok_next = (tag_reg.first ? 1'b1 : ok_reg) && c_walk
               && (tag_reg.first || step_ok);
    end

    // Tag aligned with RAM read data, running result, output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            ok_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg  <= tag;
            done_reg <= tag_reg.valid && tag_reg.last;
            if (tag_reg.valid)
            begin
                ok_reg <= ok_next;
            end
        end
    end

    // Previous-cell payload and result value
    always_ff @(posedge clk)
    begin
        if (tag_reg.valid)
        begin
            ph_reg    <= c_height;
            pw_reg    <= c_weight;
            clear_reg <= ok_next;
        end
    end

    assign busy       = tag_reg.valid;
    assign done       = done_reg;
    assign line_clear = clear_reg;

endmodule

// File: hdl/grid_line_of_walk_check.sv
// Top level of the grid line-of-walk checker: config, clamping, RAM and walk control.
// Write transaction: no result; busy stays low.
// Query: reads N = max(|dx|,|dy|)+1 cells, one RAM read per cycle from the Bresenham
// stepper while busy; done then pulses for a single cycle. No new transaction while busy.
// Reset clears control state and loads the config defaults; the cell RAM is not cleared.
// Results cannot be stalled by the receiver.
`include "assert_macros.svh"

module grid_line_of_walk_check
    import glw_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   kind,
    input  logic [COORD_W-1:0]     cell_col,
    input  logic [COORD_W-1:0]     cell_row,
    input  logic [HEIGHT_BITS-1:0] cell_height,
    input  logic [WEIGHT_BITS-1:0] cell_weight,
    input  logic                   cell_walkable,
    input  logic [COORD_W-1:0]     start_col,
    input  logic [COORD_W-1:0]     start_row,
    input  logic [COORD_W-1:0]     end_col,
    input  logic [COORD_W-1:0]     end_row,
    output logic                   done,
    output logic                   line_clear,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int ROW_BITS = $clog2(MAX_ROWS);
    localparam int CDW      = $clog2(MAX_COLS + 1);
    localparam int RDW      = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W   = COL_BITS + ROW_BITS;
    localparam int CELL_W   = HEIGHT_BITS + WEIGHT_BITS + 1;

    logic [DIM_REG_W-1:0]  grid_cols_reg, grid_rows_reg;
    logic [STEP_W-1:0]     max_step_reg;
    logic [CDW-1:0]        eff_cols;
    logic [RDW-1:0]        eff_rows;
    logic                  accept, wr_en, go;
    logic                  gen_busy, chk_busy;
    logic [COL_BITS-1:0]   x0, x1, rd_col;
    logic [ROW_BITS-1:0]   y0, y1, rd_row;
    rd_tag_t               rd_tag;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [CELL_W-1:0]     wdata, rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= RST_GRID_COLS;
            grid_rows_reg <= RST_GRID_ROWS;
            max_step_reg  <= RST_MAX_HEIGHT_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_COLS:       grid_cols_reg <= cfg_data[DIM_REG_W-1:0];
                CFG_GRID_ROWS:       grid_rows_reg <= cfg_data[DIM_REG_W-1:0];
                CFG_MAX_HEIGHT_STEP: max_step_reg  <= cfg_data[STEP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Grid size in use: zero acts as one, saturate at the maximum
    always_comb
    begin
        if (grid_cols_reg == '0)
            eff_cols = CDW'(1);
        else if (int'(grid_cols_reg) > MAX_COLS)
            eff_cols = CDW'(MAX_COLS);
        else
            eff_cols = CDW'(grid_cols_reg);
        if (grid_rows_reg == '0)
            eff_rows = RDW'(1);
        else if (int'(grid_rows_reg) > MAX_ROWS)
            eff_rows = RDW'(MAX_ROWS);
        else
            eff_rows = RDW'(grid_rows_reg);
    end

    function automatic logic [COL_BITS-1:0] clamp_col(input logic [COORD_W-1:0] v,
                                                      input logic [CDW-1:0] lim);
        if (int'(v) >= int'(lim))
            return COL_BITS'(lim - CDW'(1));
        return COL_BITS'(v);
    endfunction

    function automatic logic [ROW_BITS-1:0] clamp_row(input logic [COORD_W-1:0] v,
                                                      input logic [RDW-1:0] lim);
        if (int'(v) >= int'(lim))
            return ROW_BITS'(lim - RDW'(1));
        return ROW_BITS'(v);
    endfunction

    assign x0 = clamp_col(start_col, eff_cols);
    assign x1 = clamp_col(end_col, eff_cols);
    assign y0 = clamp_row(start_row, eff_rows);
    assign y1 = clamp_row(end_row, eff_rows);

    // Transaction accept; busy interlock keeps writes off the RAM during a walk
    assign busy   = gen_busy | chk_busy;
    assign accept = start && !busy;
    assign go     = accept && (kind == KIND_QUERY);
    assign wr_en  = accept && (kind == KIND_WRITE)
                 && (int'(cell_col) < MAX_COLS) && (int'(cell_row) < MAX_ROWS);
    assign waddr  = {ROW_BITS'(cell_row), COL_BITS'(cell_col)};
    assign wdata  = {cell_walkable, cell_weight, cell_height};
    assign raddr  = {rd_row, rd_col};

    glw_cell_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    glw_line_gen #(
        .COL_BITS (COL_BITS),
        .ROW_BITS (ROW_BITS)
    ) u_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .x0     (x0),
        .y0     (y0),
        .x1     (x1),
        .y1     (y1),
        .busy   (gen_busy),
        .rd_col (rd_col),
        .rd_row (rd_row),
        .rd_tag (rd_tag)
    );

    glw_check #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (rd_tag),
        .cell_word  (rdata),
        .max_step   (max_step_reg),
        .busy       (chk_busy),
        .done       (done),
        .line_clear (line_clear)
    );

    // Checks
    `GLW_ASSERT(a_query_goes_busy, clk, rst_n, (start && !busy && kind == KIND_QUERY) |=> busy)
    `GLW_ASSERT(a_write_stays_idle, clk, rst_n, (start && !busy && kind == KIND_WRITE) |=> !busy)
    `GLW_ASSERT(a_done_after_walk, clk, rst_n, done |-> $past(chk_busy))
    `GLW_ASSERT(a_done_single, clk, rst_n, done |=> !done)
    `GLW_NEVER(a_no_write_in_walk, clk, rst_n, wr_en && (gen_busy || chk_busy))

endmodule
